[rtl/msd_pkg.sv]
// Shared types, constants and the letter lookup for the Morse sample decoder.
// No dependencies; every other file in rtl/ imports this package.
package msd_pkg;

  localparam int MAX_SYMBOLS  = 4;
  localparam int LETTER_COUNT = 26;
  localparam int RUN_W        = 6;
  localparam int SYM_CNT_W    = $clog2(MAX_SYMBOLS + 2);
  localparam int LETTER_W     = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int EVQ_DEPTH    = 4;
  localparam int EVQ_AW       = $clog2(EVQ_DEPTH);

  localparam logic [RUN_W-1:0]    RUN_SAT = '1;
  localparam logic [LETTER_W-1:0] ASCII_A = 7'd65;

  localparam logic [RUN_W-1:0] DOT_MAX_RST        = 6'd3;
  localparam logic [RUN_W-1:0] DASH_MIN_RST       = 6'd4;
  localparam logic [RUN_W-1:0] DASH_MAX_RST       = 6'd9;
  localparam logic [RUN_W-1:0] SYMBOL_GAP_MAX_RST = 6'd3;
  localparam logic [RUN_W-1:0] LETTER_GAP_MAX_RST = 6'd9;
  localparam logic [RUN_W-1:0] WORD_GAP_MAX_RST   = 6'd21;

  // Morse pattern per letter A..Z: symbol count, then bits (first symbol
  // highest, dot 0, dash 1).
  localparam logic [SYM_CNT_W-1:0] CODE_LEN [LETTER_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [MAX_SYMBOLS-1:0] CODE_BITS [LETTER_COUNT] = '{
    4'd1, 4'd8, 4'd10, 4'd4, 4'd0, 4'd2, 4'd6, 4'd0, 4'd0, 4'd7, 4'd5, 4'd4, 4'd3,
    4'd2, 4'd7, 4'd6, 4'd13, 4'd2, 4'd0, 4'd1, 4'd1, 4'd1, 4'd3, 4'd9, 4'd11, 4'd12
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOT_MAX        = 3'd0,
    CFG_DASH_MIN       = 3'd1,
    CFG_DASH_MAX       = 3'd2,
    CFG_SYMBOL_GAP_MAX = 3'd3,
    CFG_LETTER_GAP_MAX = 3'd4,
    CFG_WORD_GAP_MAX   = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RECV = 1'b1
  } front_state_t;

  typedef struct packed {
    logic [RUN_W-1:0] dot_max;
    logic [RUN_W-1:0] dash_min;
    logic [RUN_W-1:0] dash_max;
    logic [RUN_W-1:0] symbol_gap_max;
    logic [RUN_W-1:0] letter_gap_max;
    logic [RUN_W-1:0] word_gap_max;
  } msd_cfg_t;

  // Letter event handed from the front to the back.
  typedef struct packed {
    logic [MAX_SYMBOLS-1:0] bits;
    logic [SYM_CNT_W-1:0]   count;
    logic                   word_end;
    logic                   frame_end;
  } msd_event_t;

  typedef struct packed {
    logic       valid;
    msd_event_t ev;
  } msd_evq_wr_t;

  function automatic logic [LETTER_W-1:0] lookup_letter(
    input logic [MAX_SYMBOLS-1:0] bits,
    input logic [SYM_CNT_W-1:0]   count
  );
    logic [LETTER_W-1:0] res;
    res = '0;
    if ((count != '0) && (count <= SYM_CNT_W'(MAX_SYMBOLS))) begin
      for (int i = 0; i < LETTER_COUNT; i++) begin
        if ((CODE_LEN[i] == count) && (CODE_BITS[i] == bits)) begin
          res = LETTER_W'(ASCII_A + LETTER_W'(i));
        end
      end
    end
    return res;
  endfunction

endpackage

[rtl/msd_front.sv]
// Front end: run counters, symbol collection and gap classification.
// Depends on msd_pkg; emits letter events towards msd_evq.
module msd_front import msd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  msd_cfg_t    cfg,
  input  logic        smp_take,
  input  logic        smp_level,
  output msd_evq_wr_t ev_wr,
  output logic        receiving
);

  front_state_t           state_r, state_nxt;
  logic [RUN_W-1:0]       high_run_r, high_run_nxt;
  logic [RUN_W-1:0]       low_run_r, low_run_nxt;
  logic [MAX_SYMBOLS-1:0] sym_bits_r, sym_bits_nxt;
  logic [SYM_CNT_W-1:0]   sym_cnt_r, sym_cnt_nxt;

  logic [RUN_W-1:0]       high_inc, low_inc;
  logic                   is_dot, is_dash;
  logic [MAX_SYMBOLS-1:0] add_bits;
  logic [SYM_CNT_W-1:0]   add_cnt;
  logic                   gap_letter, gap_word, frame_hit;

  assign high_inc = (high_run_r == RUN_SAT) ? high_run_r : high_run_r + RUN_W'(1);
  assign low_inc  = (low_run_r == RUN_SAT) ? low_run_r : low_run_r + RUN_W'(1);

  // Dot wins when both ranges match.
  assign is_dot  = (high_run_r != '0) && (high_run_r <= cfg.dot_max);
  assign is_dash = (high_run_r != '0) && !is_dot && (high_run_r >= cfg.dash_min) &&
                   (high_run_r <= cfg.dash_max);

  always_comb begin
    add_bits = sym_bits_r;
    add_cnt  = sym_cnt_r;
    if (is_dot || is_dash) begin
      if (sym_cnt_r < SYM_CNT_W'(MAX_SYMBOLS)) begin
        add_bits = {sym_bits_r[MAX_SYMBOLS-2:0], is_dash};
        add_cnt  = sym_cnt_r + SYM_CNT_W'(1);
      end else begin
        add_cnt  = SYM_CNT_W'(MAX_SYMBOLS + 1);
      end
    end
  end

  assign gap_letter = (low_run_r > cfg.symbol_gap_max) && (low_run_r <= cfg.letter_gap_max);
  assign gap_word   = (low_run_r > cfg.symbol_gap_max) && !gap_letter &&
                      (low_run_r <= cfg.word_gap_max);
  assign frame_hit  = (low_inc > cfg.word_gap_max) || (low_inc == RUN_SAT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (smp_take && smp_level) begin
          state_nxt = ST_RECV;
        end
      end
      ST_RECV: begin
        if (smp_take && !smp_level && frame_hit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    high_run_nxt = high_run_r;
    low_run_nxt  = low_run_r;
    sym_bits_nxt = sym_bits_r;
    sym_cnt_nxt  = sym_cnt_r;
    ev_wr        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (smp_take && smp_level) begin
          high_run_nxt = RUN_W'(1);
          low_run_nxt  = '0;
        end
      end
      ST_RECV: begin
        if (smp_take && smp_level) begin
          high_run_nxt = high_inc;
          low_run_nxt  = '0;
          if (gap_letter || gap_word) begin
            ev_wr.valid        = 1'b1;
            ev_wr.ev.bits      = sym_bits_r;
            ev_wr.ev.count     = sym_cnt_r;
            ev_wr.ev.word_end  = gap_word;
            sym_bits_nxt       = '0;
            sym_cnt_nxt        = '0;
          end
        end else if (smp_take) begin
          sym_bits_nxt = add_bits;
          sym_cnt_nxt  = add_cnt;
          high_run_nxt = '0;
          low_run_nxt  = low_inc;
          if (frame_hit) begin
            // Flush the pending letter and drop back to idle.
            ev_wr.valid        = 1'b1;
            ev_wr.ev.bits      = add_bits;
            ev_wr.ev.count     = add_cnt;
            ev_wr.ev.word_end  = 1'b1;
            ev_wr.ev.frame_end = 1'b1;
            sym_bits_nxt       = '0;
            sym_cnt_nxt        = '0;
            low_run_nxt        = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      high_run_r <= '0;
      low_run_r  <= '0;
      sym_bits_r <= '0;
      sym_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      high_run_r <= high_run_nxt;
      low_run_r  <= low_run_nxt;
      sym_bits_r <= sym_bits_nxt;
      sym_cnt_r  <= sym_cnt_nxt;
    end
  end

  assign receiving = (state_r == ST_RECV);

endmodule

[rtl/msd_evq.sv]
// Short event queue between the front and back ends.
// Depends on msd_pkg for the event type and depth.
module msd_evq import msd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  msd_evq_wr_t wr,
  input  logic        rd_pop,
  output logic        rd_valid,
  output msd_event_t  rd_ev,
  output logic        full
);

  msd_event_t        mem_r [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [EVQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [EVQ_AW:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign do_push  = wr.valid && !full;
  assign do_pop   = rd_pop && rd_valid;
  assign rd_valid = (cnt_r != '0);
  assign full     = (cnt_r == (EVQ_AW+1)'(EVQ_DEPTH));
  assign rd_ev    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + EVQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + EVQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (EVQ_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (EVQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/msd_back.sv]
// Back end: letter table lookup into the result register.
// Depends on msd_pkg for lookup_letter and the event type.
module msd_back import msd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ev_valid,
  input  msd_event_t          ev,
  output logic                ev_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [LETTER_W-1:0] out_letter,
  output logic                out_word_end,
  output logic                out_frame_end
);

  logic                out_valid_r, out_valid_nxt;
  logic [LETTER_W-1:0] letter_r;
  logic                word_end_r, frame_end_r;

  // Load whenever the result register is free or being drained.
  assign ev_pop        = ev_valid && (!out_valid_r || out_pop);
  assign out_valid_nxt = ev_pop || (out_valid_r && !out_pop);

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      letter_r    <= lookup_letter(ev.bits, ev.count);
      word_end_r  <= ev.word_end;
      frame_end_r <= ev.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_letter    = letter_r;
  assign out_word_end  = word_end_r;
  assign out_frame_end = frame_end_r;

endmodule

[rtl/morse_sample_decoder_core.sv]
// Morse sample decoder top level: config registers, front end, event queue, back end.
// Depends on msd_pkg, msd_front, msd_evq and msd_back.
// Throughput: one line sample accepted every cycle; in_full rises only when the
//   four-entry event queue is full because results are not being popped.
// A letter's event is written into the event queue on the transfer of the sample that
//   ends it, then loaded into the result register before it shows on the result ports.
// Reset (rst_n low at a clock edge): idle, event queue and result register empty, registers back to defaults.
module morse_sample_decoder_core import msd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_level,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [LETTER_W-1:0]  out_letter,
  output logic                 out_word_end,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RUN_W-1:0]     cfg_data
);

  msd_cfg_t        cfg_r, cfg_nxt;
  msd_evq_wr_t     ev_wr;
  msd_event_t      q_ev;
  logic            q_full;
  logic            front_receiving;
  logic            smp_take;
  logic            q_valid, q_pop;

  // Configuration transfers are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DOT_MAX:        cfg_nxt.dot_max        = cfg_data;
        CFG_DASH_MIN:       cfg_nxt.dash_min       = cfg_data;
        CFG_DASH_MAX:       cfg_nxt.dash_max       = cfg_data;
        CFG_SYMBOL_GAP_MAX: cfg_nxt.symbol_gap_max = cfg_data;
        CFG_LETTER_GAP_MAX: cfg_nxt.letter_gap_max = cfg_data;
        CFG_WORD_GAP_MAX:   cfg_nxt.word_gap_max   = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_max        <= DOT_MAX_RST;
      cfg_r.dash_min       <= DASH_MIN_RST;
      cfg_r.dash_max       <= DASH_MAX_RST;
      cfg_r.symbol_gap_max <= SYMBOL_GAP_MAX_RST;
      cfg_r.letter_gap_max <= LETTER_GAP_MAX_RST;
      cfg_r.word_gap_max   <= WORD_GAP_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold off samples while the event queue cannot take a possible letter.
  assign in_full  = q_full;
  assign smp_take = in_push && !in_full;

  msd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .smp_take  (smp_take),
    .smp_level (in_level),
    .ev_wr     (ev_wr),
    .receiving (front_receiving)
  );

  msd_evq u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (ev_wr),
    .rd_pop   (q_pop),
    .rd_valid (q_valid),
    .rd_ev    (q_ev),
    .full     (q_full)
  );

  msd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_valid      (q_valid),
    .ev            (q_ev),
    .ev_pop        (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_letter    (out_letter),
    .out_word_end  (out_word_end),
    .out_frame_end (out_frame_end)
  );

  // A frame end always closes a word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_end) |-> out_word_end)
    else $error("frame end result without word end");

  // A shown letter is either no match or one of A..Z.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_letter == '0) ||
                    ((out_letter >= ASCII_A) &&
                     (out_letter < LETTER_W'(ASCII_A + LETTER_W'(LETTER_COUNT))))))
    else $error("letter code out of range");

  // Flushing the frame returns the front end to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ev_wr.valid && ev_wr.ev.frame_end) |=> !front_receiving)
    else $error("front end still receiving after frame end");

  // Letter events are only raised while inside a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    ev_wr.valid |-> front_receiving)
    else $error("letter event while idle");

endmodule
